>>> src/fsa_pkg.sv
// Shared types, constants and helpers for the fixed slot allocator.
// No dependencies; imported by fsa_engine and fixed_slot_allocator_unit.
`default_nettype none
package fsa_pkg;

   localparam int ADDR_SPACE    = 4096;
   localparam int INITIAL_ITEMS = 32;
   localparam int HANDLE_W      = 12;
   localparam int OFFSET_W      = 13;
   localparam int REGION_W      = 14;
   localparam int OBJ_SIZE_W    = 9;
   localparam int ADDR_LIMIT_W  = 13;
   localparam int WALK_W        = 13;

   localparam logic [OFFSET_W-1:0]     START_OFFSET  = 13'd8;
   localparam logic [REGION_W-1:0]     REGION_MAX    = 14'd16383;
   localparam logic [ADDR_LIMIT_W-1:0] LIMIT_CAP     = 13'(ADDR_SPACE < 4096 ? ADDR_SPACE : 4096);
   localparam logic [WALK_W-1:0]       WALK_MAX      = 13'(ADDR_SPACE);
   localparam logic [OBJ_SIZE_W-1:0]   OBJ_SIZE_RST  = 9'd8;
   localparam logic [ADDR_LIMIT_W-1:0] ADDR_LIMIT_RST = 13'd4096;

   // command codes
   localparam logic [1:0] CMD_ALLOC    = 2'd0;
   localparam logic [1:0] CMD_FREE     = 2'd1;
   localparam logic [1:0] CMD_VALIDATE = 2'd2;

   // configuration register indexes
   localparam logic CSR_OBJECT_SIZE   = 1'b0;
   localparam logic CSR_ADDRESS_LIMIT = 1'b1;

   typedef struct packed {
      logic [OBJ_SIZE_W-1:0]   object_size;
      logic [ADDR_LIMIT_W-1:0] address_limit;
   } cfg_type;

   typedef struct packed {
      logic                load;
      logic [REGION_W-1:0] size;
   } region_load_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic                success;
      logic                fail;
   } result_type;

   // 8 + INITIAL_ITEMS * object_size, saturated to the region width
   function automatic logic [REGION_W-1:0] init_region(input logic [OBJ_SIZE_W-1:0] os);
      logic [REGION_W+4:0] r;
      r = (REGION_W+5)'(START_OFFSET) + (REGION_W+5)'(os) * (REGION_W+5)'(INITIAL_ITEMS);
      init_region = (r > (REGION_W+5)'(REGION_MAX)) ? REGION_MAX : r[REGION_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> src/fsa_engine.sv
// Allocator engine: command sequencer, allocator state and the link memory.
// Depends on fsa_pkg.
`default_nettype none
module fsa_engine
   import fsa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [HANDLE_W-1:0] req_handle,
   input  wire cfg_type             cfg,
   input  wire region_load_type     region_load,
   input  wire logic                out_free,
   output logic                     idle,
   output logic                     done,
   output result_type               result
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_POP  = 3'd2;
   localparam logic [2:0] S_LINK = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [HANDLE_W-1:0] free_head_ff, free_head_in;
   logic [OFFSET_W-1:0] bump_ff, bump_in;
   logic [REGION_W-1:0] region_ff, region_in;
   logic                fail_ff, fail_in;
   logic [WALK_W-1:0]   walk_cnt_ff, walk_cnt_in;
   result_type          res_ff, res_in;

   // one link word per handle; never cleared, only pushed handles are read
   logic [HANDLE_W-1:0] link_mem [ADDR_SPACE];
   logic [HANDLE_W-1:0] rdata_ff;
   logic                rd_en, wr_en;
   logic [HANDLE_W-1:0] rd_addr;

   logic [REGION_W-1:0]   bump_end;
   logic [REGION_W-1:0]   eff_limit;
   logic [REGION_W:0]     region_dbl;
   logic [REGION_W-1:0]   region_grown;
   logic signed [REGION_W+1:0] range_top;
   logic                  in_range;

   always_comb begin
      bump_end     = REGION_W'(bump_ff) + REGION_W'(cfg.object_size);
      eff_limit    = REGION_W'((cfg.address_limit > LIMIT_CAP) ? LIMIT_CAP
                                                                : cfg.address_limit);
      region_dbl   = {region_ff, 1'b0};
      region_grown = (region_dbl > (REGION_W+1)'(REGION_MAX)) ? REGION_MAX
                                                              : region_dbl[REGION_W-1:0];
      range_top    = $signed((REGION_W+2)'(region_ff)) - $signed((REGION_W+2)'(cfg.object_size));
      in_range     = (handle_ff != '0) && ($signed((REGION_W+2)'(handle_ff)) <= range_top);
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      handle_in    = handle_ff;
      free_head_in = free_head_ff;
      bump_in      = bump_ff;
      region_in    = region_ff;
      fail_in      = fail_ff;
      walk_cnt_in  = walk_cnt_ff;
      res_in       = res_ff;
      rd_en        = 1'b0;
      rd_addr      = free_head_ff;
      wr_en        = 1'b0;
      done         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               handle_in = req_handle;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            res_in   = '{handle: '0, success: 1'b0, fail: fail_ff};
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (free_head_ff != '0) begin
                     rd_en    = 1'b1;
                     state_in = S_POP;
                  end else if (bump_end >= eff_limit) begin
                     fail_in = 1'b1;
                     res_in  = '{handle: '0, success: 1'b0, fail: 1'b1};
                  end else begin
                     if (bump_end > region_ff) begin
                        region_in = region_grown;
                     end
                     res_in  = '{handle: bump_ff[HANDLE_W-1:0], success: 1'b1, fail: fail_ff};
                     bump_in = bump_end[OFFSET_W-1:0];
                  end
               end
               CMD_FREE: begin
                  if (!in_range) begin
                     res_in = '{handle: '0, success: 1'b0, fail: fail_ff};
                  end else if (free_head_ff == '0) begin
                     wr_en        = 1'b1;
                     free_head_in = handle_ff;
                     res_in       = '{handle: '0, success: 1'b1, fail: fail_ff};
                  end else if (free_head_ff == handle_ff) begin
                     res_in = '{handle: '0, success: 1'b0, fail: fail_ff};
                  end else begin
                     rd_en       = 1'b1;
                     walk_cnt_in = WALK_W'(1);
                     state_in    = S_LINK;
                  end
               end
               CMD_VALIDATE: begin
                  res_in = '{handle: '0, success: in_range, fail: fail_ff};
               end
               default: begin
                  res_in = '{handle: '0, success: 1'b0, fail: fail_ff};
               end
            endcase
         end
         S_POP: begin
            free_head_in = rdata_ff;
            res_in       = '{handle: free_head_ff, success: 1'b1, fail: fail_ff};
            state_in     = S_DONE;
         end
         S_LINK: begin
            // rdata_ff holds the next link of the walk
            if ((rdata_ff == '0) || (walk_cnt_ff == WALK_MAX)) begin
               wr_en        = 1'b1;
               free_head_in = handle_ff;
               res_in       = '{handle: '0, success: 1'b1, fail: fail_ff};
               state_in     = S_DONE;
            end else if (rdata_ff == handle_ff) begin
               res_in   = '{handle: '0, success: 1'b0, fail: fail_ff};
               state_in = S_DONE;
            end else begin
               rd_en       = 1'b1;
               rd_addr     = rdata_ff;
               walk_cnt_in = walk_cnt_ff + WALK_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // object size write reloads the region; the user must write it only while idle, the block does not enforce it
      if (region_load.load) begin
         region_in = region_load.size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= '0;
         bump_ff      <= START_OFFSET;
         region_ff    <= init_region(OBJ_SIZE_RST);
         fail_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         bump_ff      <= bump_in;
         region_ff    <= region_in;
         fail_ff      <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      handle_ff   <= handle_in;
      walk_cnt_ff <= walk_cnt_in;
      res_ff      <= res_in;
   end

   // reads and writes never fall in the same cycle: one item at a time
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[handle_ff] <= free_head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= link_mem[rd_addr];
      end
   end

   assign idle   = (state_ff == S_IDLE);
   assign result = res_ff;

endmodule
`default_nettype wire

>>> src/fixed_slot_allocator_unit.sv
// Top level of the fixed slot allocator: stream ports, configuration registers
// and the result register. Depends on fsa_pkg and fsa_engine.
`default_nettype none
// Fixed-size slot allocator handing out 12-bit byte-offset handles. Send one
// item per command on req_ (cmd in req_tuser: allocate, free, validate) and
// take exactly one item back on rsp_. An allocate pops the free list when it
// is not empty, otherwise it bumps an offset starting at 8 by object_size;
// reaching the address limit refuses the allocate and sets the sticky
// fail_reason, which only reset clears. A free is range checked, then the
// free list is walked one link per cycle to reject a double free, then the
// handle is pushed. The block works on one item at a time. Every item
// passes the EXEC and DONE states; an allocate from the free list also
// passes POP, and a free that reads links passes LINK once for each link
// read. The walk is bounded by the single-port link memory giving one read
// per cycle. After its result is handed over in DONE, which waits until
// the output register can take it, the engine returns to idle and the
// next item is accepted. A finished result waits in the output register
// while the next item is accepted. The link memory is never cleared, so
// no initialization pass follows reset. Write configuration only while
// no item is in flight; writing object_size also resets the tracked
// region size to 8 + 32 * object_size.
module fixed_slot_allocator_unit
   import fsa_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [15:0]             req_tdata,   // [11:0] handle_in, rest zero
   input  wire logic [1:0]              req_tuser,   // [1:0] cmd
   // result channel
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [15:0]                  rsp_tdata,   // [11:0] handle_out, rest zero
   output logic [1:0]                   rsp_tuser,   // [0] success, [1] fail_reason
   // configuration write port
   input  wire logic                    csr_we,
   input  wire logic                    csr_index,
   input  wire logic [ADDR_LIMIT_W-1:0] csr_wdata
);

   logic [OBJ_SIZE_W-1:0]   object_size_ff, object_size_in;
   logic [ADDR_LIMIT_W-1:0] address_limit_ff, address_limit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_res_ff, rsp_res_in;

   cfg_type         cfg;
   region_load_type region_load;
   result_type      eng_result;
   logic            eng_idle;
   logic            eng_done;
   logic            out_free;

   // hold configuration; an object size write reloads the region size
   always_comb begin
      object_size_in   = object_size_ff;
      address_limit_in = address_limit_ff;
      region_load      = '{load: 1'b0, size: init_region(csr_wdata[OBJ_SIZE_W-1:0])};
      if (csr_we) begin
         unique case (csr_index)
            CSR_OBJECT_SIZE: begin
               object_size_in   = csr_wdata[OBJ_SIZE_W-1:0];
               region_load.load = 1'b1;
            end
            CSR_ADDRESS_LIMIT: begin
               address_limit_in = csr_wdata;
            end
            default: begin
               object_size_in = object_size_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         object_size_ff   <= OBJ_SIZE_RST;
         address_limit_ff <= ADDR_LIMIT_RST;
      end else begin
         object_size_ff   <= object_size_in;
         address_limit_ff <= address_limit_in;
      end
   end

   assign cfg = '{object_size: object_size_ff, address_limit: address_limit_ff};

   // the engine may hand over a result when the output register is empty or drains this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   fsa_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_cmd     (req_tuser),
      .req_handle  (req_tdata[HANDLE_W-1:0]),
      .cfg         (cfg),
      .region_load (region_load),
      .out_free    (out_free),
      .idle        (eng_idle),
      .done        (eng_done),
      .result      (eng_result)
   );

   assign req_tready = eng_idle;

   // output register: load a finished item, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (eng_done) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = eng_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_res_ff.handle};
   assign rsp_tuser  = {rsp_res_ff.fail, rsp_res_ff.success};

endmodule
`default_nettype wire
